// File: src/ersc_pkg.sv
// Package for the event record sequence checker.
// Holds the field widths, event kinds, status codes, the record, state and result types.
// No dependencies.
package ersc_pkg;

    localparam int SecW   = 32;
    localparam int NsecW  = 30;
    localparam int ProcW  = 31;
    localparam int KindW  = 2;
    localparam int SigW   = 64;
    localparam int HashW  = 32;
    localparam int StatW  = 3;

    // Event kinds
    localparam logic [KindW-1:0] KIND_ENTRY = 2'd0;
    localparam logic [KindW-1:0] KIND_EXIT  = 2'd1;
    localparam logic [KindW-1:0] KIND_EPOCH = 2'd2;
    localparam logic [KindW-1:0] KIND_OTHER = 2'd3;

    // Status codes
    localparam logic [StatW-1:0] ST_OK       = 3'd0;
    localparam logic [StatW-1:0] ST_PROCESS  = 3'd1;
    localparam logic [StatW-1:0] ST_TIME     = 3'd2;
    localparam logic [StatW-1:0] ST_BAD_HASH = 3'd3;
    localparam logic [StatW-1:0] ST_NESTED   = 3'd4;
    localparam logic [StatW-1:0] ST_NO_ENTRY = 3'd5;
    localparam logic [StatW-1:0] ST_MISMATCH = 3'd6;
    localparam logic [StatW-1:0] ST_EPOCH    = 3'd7;

    typedef struct packed {
        logic [SecW-1:0]  time_sec;
        logic [NsecW-1:0] time_nsec;
        logic [ProcW-1:0] process_id;
        logic [KindW-1:0] event_kind;
        logic [SigW-1:0]  signal_value;
    } rec_t;

    typedef struct packed {
        logic             seen_first;
        logic [SecW-1:0]  last_sec;
        logic [NsecW-1:0] last_nsec;
        logic [ProcW-1:0] owner_process;
        logic [HashW-1:0] region_open_hash;
        logic [SigW-1:0]  epoch_seen;
    } state_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [HashW-1:0] open_region;
        logic [SigW-1:0]  epoch_now;
    } res_t;

endpackage

// File: src/ersc_intf.sv
// Channel interfaces for the event record sequence checker.
// Depends on ersc_pkg for field widths.
interface ersc_rec_if;
    logic                          valid;
    logic                          ready;
    logic [ersc_pkg::SecW-1:0]     time_sec;
    logic [ersc_pkg::NsecW-1:0]    time_nsec;
    logic [ersc_pkg::ProcW-1:0]    process_id;
    logic [ersc_pkg::KindW-1:0]    event_kind;
    logic [ersc_pkg::SigW-1:0]     signal_value;

    modport source (output valid, time_sec, time_nsec, process_id, event_kind,
                    signal_value, input ready);
    modport sink (input valid, time_sec, time_nsec, process_id, event_kind,
                  signal_value, output ready);
endinterface

interface ersc_res_if;
    logic                          valid;
    logic                          ready;
    logic [ersc_pkg::StatW-1:0]    status;
    logic [ersc_pkg::HashW-1:0]    open_region;
    logic [ersc_pkg::SigW-1:0]     epoch_now;

    modport source (output valid, status, open_region, epoch_now, input ready);
    modport sink (input valid, status, open_region, epoch_now, output ready);
endinterface

interface ersc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ersc_pkg::HashW-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: src/ersc_core.sv
// Check logic for one record: status code and next checker state.
// Purely combinational; depends on ersc_pkg.
module ersc_core
(
    input  ersc_pkg::rec_t                 rec_in,
    input  ersc_pkg::state_t               state_in,
    input  logic [ersc_pkg::HashW-1:0]     invalid_hash,
    output logic [ersc_pkg::StatW-1:0]     status,
    output ersc_pkg::state_t               state_out
);

    ersc_pkg::state_t          eff;
    logic                      proc_ok;
    logic                      time_ok;
    logic                      hash_bad;
    logic [ersc_pkg::SigW-1:0] epoch_inc;
    logic [ersc_pkg::StatW-1:0] ev_status;

    // First record latches process, time, region and epoch
    always_comb
    begin
        eff = state_in;
        if (!state_in.seen_first)
        begin
            eff.last_sec         = rec_in.time_sec;
            eff.last_nsec        = rec_in.time_nsec;
            eff.owner_process    = rec_in.process_id;
            eff.epoch_seen       = '0;
            eff.region_open_hash = invalid_hash;
        end
        eff.seen_first = 1'b1;
    end

    // Process and time checks, seconds then raw nanoseconds
    assign proc_ok = (rec_in.process_id == eff.owner_process);
    assign time_ok = !((rec_in.time_sec < eff.last_sec) ||
                       ((rec_in.time_sec == eff.last_sec) &&
                        (rec_in.time_nsec < eff.last_nsec)));

    assign hash_bad  = (rec_in.signal_value[ersc_pkg::SigW-1:ersc_pkg::HashW] != '0) ||
                       (rec_in.signal_value[ersc_pkg::HashW-1:0] == invalid_hash);
    assign epoch_inc = eff.epoch_seen + 64'd1;

    // Event check
    always_comb
    begin
        ev_status = ersc_pkg::ST_OK;
        case (rec_in.event_kind)
            ersc_pkg::KIND_ENTRY:
            begin
                if (hash_bad)
                    ev_status = ersc_pkg::ST_BAD_HASH;
                else if (eff.region_open_hash != invalid_hash)
                    ev_status = ersc_pkg::ST_NESTED;
            end
            ersc_pkg::KIND_EXIT:
            begin
                if (hash_bad)
                    ev_status = ersc_pkg::ST_BAD_HASH;
                else if (eff.region_open_hash == invalid_hash)
                    ev_status = ersc_pkg::ST_NO_ENTRY;
                else if (rec_in.signal_value[ersc_pkg::HashW-1:0] != eff.region_open_hash)
                    ev_status = ersc_pkg::ST_MISMATCH;
            end
            ersc_pkg::KIND_EPOCH:
            begin
                if (rec_in.signal_value != epoch_inc)
                    ev_status = ersc_pkg::ST_EPOCH;
            end
            default:
            begin
                ev_status = ersc_pkg::ST_OK;
            end
        endcase
    end

    // Status and state update, stopping at the first failing check
    always_comb
    begin
        state_out = eff;
        if (!proc_ok)
            status = ersc_pkg::ST_PROCESS;
        else if (!time_ok)
            status = ersc_pkg::ST_TIME;
        else
        begin
            status              = ev_status;
            state_out.last_sec  = rec_in.time_sec;
            state_out.last_nsec = rec_in.time_nsec;
            if (ev_status == ersc_pkg::ST_OK)
            begin
                case (rec_in.event_kind)
                    ersc_pkg::KIND_ENTRY:
                        state_out.region_open_hash = rec_in.signal_value[ersc_pkg::HashW-1:0];
                    ersc_pkg::KIND_EXIT:
                        state_out.region_open_hash = invalid_hash;
                    ersc_pkg::KIND_EPOCH:
                        state_out.epoch_seen = rec_in.signal_value;
                    default:
                        state_out.epoch_seen = eff.epoch_seen;
                endcase
            end
        end
    end

endmodule

// File: src/event_record_sequence_checker.sv
// Top level of the event record sequence checker.
// Depends on ersc_pkg, the channel interfaces and ersc_core.
//
//   channel | dir | carries
//   --------+-----+-------------------------------------------------
//   rec     | in  | time_sec, time_nsec, process_id, event_kind, signal_value
//   res     | out | status, open_region, epoch_now (one per record)
//   cfg     | in  | invalid_hash write data
//
// One record per cycle sustained while res is ready. A rec transfer loads the
// input register; the check logic then moves the record into the result
// register, which drives res valid. A stalled res can hold it in the input register.
// State updates when a record moves into the result register, so the next
// record sees it at once. A stalled res holds its result; rec keeps taking a
// record while the input register can move on. Reset clears the checker state
// and valid flags and sets invalid_hash and the open region to zero.
module event_record_sequence_checker
(
    input  logic         clk,
    input  logic         rst_n,
    ersc_rec_if.sink     rec,
    ersc_res_if.source   res,
    ersc_cfg_if.sink     cfg
);

    logic                          in_valid_reg;
    ersc_pkg::rec_t                in_rec_reg;
    logic                          out_valid_reg;
    ersc_pkg::res_t                out_res_reg;
    ersc_pkg::state_t              state_reg;
    ersc_pkg::state_t              state_next;
    logic [ersc_pkg::HashW-1:0]    invalid_hash_reg;
    logic [ersc_pkg::StatW-1:0]    status_c;
    logic                          advance;
    ersc_pkg::rec_t                rec_c;

    // Handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign rec.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    assign rec_c.time_sec     = rec.time_sec;
    assign rec_c.time_nsec    = rec.time_nsec;
    assign rec_c.process_id   = rec.process_id;
    assign rec_c.event_kind   = rec.event_kind;
    assign rec_c.signal_value = rec.signal_value;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            invalid_hash_reg <= '0;
        else if (cfg.valid && cfg.ready)
            invalid_hash_reg <= cfg.data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rec.ready)
            in_valid_reg <= rec.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rec.valid && rec.ready)
            in_rec_reg <= rec_c;
    end

    ersc_core u_core
    (
        .rec_in       (in_rec_reg),
        .state_in     (state_reg),
        .invalid_hash (invalid_hash_reg),
        .status       (status_c),
        .state_out    (state_next)
    );

    // Checker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg.status      <= status_c;
            out_res_reg.open_region <= state_next.region_open_hash;
            out_res_reg.epoch_now   <= state_next.epoch_seen;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_res_reg.status;
    assign res.open_region = out_res_reg.open_region;
    assign res.epoch_now   = out_res_reg.epoch_now;

    // Assertions
    a_seen_after_record: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> state_reg.seen_first)
        else $error("first-record latch not set after a record");

    a_proc_fail_keeps_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && state_reg.seen_first && (status_c == ersc_pkg::ST_PROCESS)
        |=> $stable(state_reg.last_sec) && $stable(state_reg.last_nsec))
        else $error("time changed on a process failure");

    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_res_reg.open_region == state_reg.region_open_hash) &&
                    (out_res_reg.epoch_now == state_reg.epoch_seen))
        else $error("result does not match stored state");

    a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !res.ready |-> !rec.ready)
        else $error("record taken while both stages are stalled");

endmodule

// File: test/tb.sv
// Testbench for event_record_sequence_checker: directed and random record streams,
// checked transfer by transfer against an in-bench model of the sequence checks.
// Depends on ersc_pkg, the channel interfaces and the RTL top level.
module tb;

    typedef logic [ersc_pkg::NsecW-1:0] nsec_t;
    typedef logic [ersc_pkg::ProcW-1:0] proc_t;
    typedef logic [ersc_pkg::KindW-1:0] kind_t;

    localparam proc_t OWNER = 31'h2A5C_3C96;

    logic clk;
    logic rst_n;

    ersc_rec_if rec_ch();
    ersc_res_if res_ch();
    ersc_cfg_if cfg_ch();

    event_record_sequence_checker dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // Model state, updated as each record transfer is accepted
    logic                       m_started = 1'b0;
    logic [ersc_pkg::SecW-1:0]  m_sec     = '0;
    logic [ersc_pkg::NsecW-1:0] m_nsec    = '0;
    logic [ersc_pkg::ProcW-1:0] m_owner   = '0;
    logic [ersc_pkg::HashW-1:0] m_region  = '0;
    logic [ersc_pkg::SigW-1:0]  m_epoch   = '0;
    logic [ersc_pkg::HashW-1:0] m_invalid = '0;

    ersc_pkg::res_t verdicts_due[$];
    int   fail_count = 0;
    int   idle_odds  = 0;   // percent chance, per record sent or per sink cycle, that an idle burst starts
    int   hold_left  = 0;   // long receiver hold-off, counted down by the sink

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Expected verdict for one record; updates the model state as the block would
    function automatic ersc_pkg::res_t judge_record(input ersc_pkg::rec_t r);
        ersc_pkg::res_t v;
        logic hash_bad;
        v.status = ersc_pkg::ST_OK;
        if (!m_started)
        begin
            m_sec     = r.time_sec;
            m_nsec    = r.time_nsec;
            m_owner   = r.process_id;
            m_epoch   = '0;
            m_region  = m_invalid;
            m_started = 1'b1;
        end
        hash_bad = (r.signal_value[63:32] != '0) || (r.signal_value[31:0] == m_invalid);
        if (r.process_id != m_owner)
            v.status = ersc_pkg::ST_PROCESS;
        else if (r.time_sec < m_sec || (r.time_sec == m_sec && r.time_nsec < m_nsec))
            v.status = ersc_pkg::ST_TIME;
        else
        begin
            m_sec  = r.time_sec;
            m_nsec = r.time_nsec;
            case (r.event_kind)
                ersc_pkg::KIND_ENTRY:
                begin
                    if (hash_bad)
                        v.status = ersc_pkg::ST_BAD_HASH;
                    else if (m_region != m_invalid)
                        v.status = ersc_pkg::ST_NESTED;
                    else
                        m_region = r.signal_value[31:0];
                end
                ersc_pkg::KIND_EXIT:
                begin
                    if (hash_bad)
                        v.status = ersc_pkg::ST_BAD_HASH;
                    else if (m_region == m_invalid)
                        v.status = ersc_pkg::ST_NO_ENTRY;
                    else if (r.signal_value != {32'h0, m_region})
                        v.status = ersc_pkg::ST_MISMATCH;
                    else
                        m_region = m_invalid;
                end
                ersc_pkg::KIND_EPOCH:
                begin
                    if (r.signal_value != m_epoch + 64'd1)
                        v.status = ersc_pkg::ST_EPOCH;
                    else
                        m_epoch = r.signal_value;
                end
                default: ;
            endcase
        end
        v.open_region = m_region;
        v.epoch_now   = m_epoch;
        return v;
    endfunction

    function automatic ersc_pkg::rec_t rec_of(input logic [ersc_pkg::SecW-1:0] sec,
                                              input nsec_t nsec, input proc_t proc,
                                              input kind_t kind,
                                              input logic [ersc_pkg::SigW-1:0] sig);
        ersc_pkg::rec_t r;
        r.time_sec     = sec;
        r.time_nsec    = nsec;
        r.process_id   = proc;
        r.event_kind   = kind;
        r.signal_value = sig;
        return r;
    endfunction

    // Random record, mostly well formed against the current model state
    function automatic ersc_pkg::rec_t make_record();
        ersc_pkg::rec_t r;
        int unsigned roll;
        logic [31:0] nsec_step;
        roll = $urandom_range(0, 99);
        r.process_id = m_owner;
        r.time_sec   = m_sec;
        r.time_nsec  = m_nsec;
        if (roll < 6)
        begin
            // foreign process, any timestamp
            r.process_id = proc_t'($urandom);
            r.time_sec   = $urandom;
            r.time_nsec  = nsec_t'($urandom);
        end
        else if (roll < 9 && m_nsec != 0)
            r.time_nsec = nsec_t'($urandom_range(0, m_nsec - 1));
        else if (roll < 12 && m_sec != 0)
        begin
            r.time_sec  = $urandom_range(0, m_sec - 1);
            r.time_nsec = nsec_t'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: ;
                1:
                begin
                    nsec_step = m_nsec + $urandom_range(1, 5000);
                    if (nsec_step <= 32'h3FFF_FFFF)
                        r.time_nsec = nsec_t'(nsec_step);
                end
                default:
                begin
                    r.time_sec = m_sec + $urandom_range(1, 3);
                    if ($urandom_range(0, 19) == 0)
                        r.time_nsec = nsec_t'($urandom_range(1_000_000_000, 32'h3FFF_FFFF));
                    else
                        r.time_nsec = nsec_t'($urandom_range(0, 999_999_999));
                end
            endcase
        end

        // Kind: favor closing an open region and opening a closed one
        if (m_region != m_invalid && $urandom_range(0, 1) == 1)
            r.event_kind = ersc_pkg::KIND_EXIT;
        else if (m_region == m_invalid && $urandom_range(0, 2) == 0)
            r.event_kind = ersc_pkg::KIND_ENTRY;
        else
            r.event_kind = kind_t'($urandom_range(0, 3));

        roll = $urandom_range(0, 99);
        case (r.event_kind)
            ersc_pkg::KIND_ENTRY, ersc_pkg::KIND_EXIT:
            begin
                if (roll < 8)
                    r.signal_value = {$urandom | 32'h1, $urandom};
                else if (roll < 14)
                    r.signal_value = {32'h0, m_invalid};
                else if (r.event_kind == ersc_pkg::KIND_EXIT && roll < 85)
                    r.signal_value = {32'h0, m_region};
                else
                    r.signal_value = {32'h0, $urandom};
            end
            ersc_pkg::KIND_EPOCH:
            begin
                if (roll < 80)
                    r.signal_value = m_epoch + 64'd1;
                else if (roll < 90)
                    r.signal_value = m_epoch + 64'($urandom_range(0, 3) * 2);
                else
                    r.signal_value = {$urandom, $urandom};
            end
            default: r.signal_value = {$urandom, $urandom};
        endcase
        return r;
    endfunction

    // One record transfer; leaves valid high unless an idle burst follows
    task automatic send_record(input ersc_pkg::rec_t r);
        rec_ch.valid        <= 1'b1;
        rec_ch.time_sec     <= r.time_sec;
        rec_ch.time_nsec    <= r.time_nsec;
        rec_ch.process_id   <= r.process_id;
        rec_ch.event_kind   <= r.event_kind;
        rec_ch.signal_value <= r.signal_value;
        do @(posedge clk); while (!rec_ch.ready);
        verdicts_due.push_back(judge_record(r));
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
        begin
            rec_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every verdict is back
    task automatic wait_drained();
        rec_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_invalid_hash(input logic [ersc_pkg::HashW-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        m_invalid = value;
    endtask

    // Result sink: checks each transfer and drives ready
    initial
    begin : result_sink
        int             stall_left;
        ersc_pkg::res_t want;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result with nothing outstanding: status %0d", res_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (res_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        fail_count++;
                    end
                    if (res_ch.open_region !== want.open_region)
                    begin
                        $error("open_region: expected %h, got %h",
                               want.open_region, res_ch.open_region);
                        fail_count++;
                    end
                    if (res_ch.epoch_now !== want.epoch_now)
                    begin
                        $error("epoch_now: expected %h, got %h", want.epoch_now, res_ch.epoch_now);
                        fail_count++;
                    end
                end
            end
            // ready for the next cycle
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // First record latches process, time and the register value written before it
    task automatic test_first_record_latch();
        write_invalid_hash(32'hFFFF_FFFF);
        send_record(rec_of(100, 30'd500, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
        wait_drained();
    endtask

    // Each status code and field extreme in turn
    task automatic test_directed_checks();
        idle_odds = 20;
        send_record(rec_of(32'hFFFF_FFFF, 30'h3FFF_FFFF, 31'h7FFF_FFFF,
                           ersc_pkg::KIND_ENTRY, '1));
        send_record(rec_of(0, 30'd0, 31'h0, ersc_pkg::KIND_OTHER, 64'h0));
        send_record(rec_of(99, 30'd900, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
        send_record(rec_of(100, 30'd499, OWNER, ersc_pkg::KIND_EPOCH, 64'd1));
        send_record(rec_of(100, 30'd500, OWNER, ersc_pkg::KIND_ENTRY, 64'h1_0000_0000));
        send_record(rec_of(101, 30'd0, OWNER, ersc_pkg::KIND_ENTRY, 64'hFFFF_FFFF));
        send_record(rec_of(101, 30'd0, OWNER, ersc_pkg::KIND_ENTRY, 64'h0));
        send_record(rec_of(101, 30'd7, OWNER, ersc_pkg::KIND_ENTRY, 64'd5));
        send_record(rec_of(101, 30'd7, OWNER, ersc_pkg::KIND_EXIT, 64'd5));
        send_record(rec_of(102, 30'd999_999_999, OWNER, ersc_pkg::KIND_EXIT,
                           64'hFFFF_FFFF_0000_0000));
        send_record(rec_of(102, 30'd999_999_999, OWNER, ersc_pkg::KIND_EXIT, 64'h0));
        send_record(rec_of(102, 30'd999_999_999, OWNER, ersc_pkg::KIND_EXIT, 64'h0));
        send_record(rec_of(102, 30'd999_999_999, OWNER, ersc_pkg::KIND_EXIT, 64'hFFFF_FFFF));
        // epoch: in order, gap, in order, backwards
        send_record(rec_of(103, 30'd0, OWNER, ersc_pkg::KIND_EPOCH, 64'd1));
        send_record(rec_of(103, 30'd0, OWNER, ersc_pkg::KIND_EPOCH, 64'd3));
        send_record(rec_of(103, 30'd0, OWNER, ersc_pkg::KIND_EPOCH, 64'd2));
        send_record(rec_of(103, 30'd0, OWNER, ersc_pkg::KIND_EPOCH, 64'd0));
        // nanoseconds past one second compare as raw values
        send_record(rec_of(103, 30'h3FFF_FFFF, OWNER, ersc_pkg::KIND_OTHER, '1));
        send_record(rec_of(103, 30'd1_000_000_000, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
        send_record(rec_of(104, 30'd0, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
        wait_drained();
    endtask

    // Changing invalid_hash leaves the stored region hash as it is
    task automatic test_hash_register_change();
        write_invalid_hash(32'h0);
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_ENTRY, 64'd9));
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_EXIT, 64'hFFFF_FFFF));
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_ENTRY, 64'h8000_0001));
        wait_drained();
        write_invalid_hash(32'h8000_0001);
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_EXIT, 64'h8000_0001));
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_ENTRY, 64'd7));
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_EXIT, 64'd7));
        wait_drained();
        write_invalid_hash(32'h0);
        send_record(rec_of(m_sec + 1, 30'd0, OWNER, ersc_pkg::KIND_EXIT, 64'h8000_0001));
        wait_drained();
    endtask

    // Random streams under several register settings and idle rates
    task automatic test_random_stream();
        logic [ersc_pkg::HashW-1:0] setting [4];
        setting = '{$urandom, 32'h0, 32'hFFFF_FFFF, $urandom};
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            write_invalid_hash(setting[ph]);
            idle_odds = (ph == 1) ? 0 : 5 + 10 * ph;
            repeat (340) send_record(make_record());
        end
        wait_drained();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        idle_odds = 0;
        hold_left = 60;
        repeat (30) send_record(make_record());
        wait_drained();
    endtask

    task automatic test_quiet_tail();
        idle_odds = 0;
        repeat (150) send_record(make_record());
    endtask

    // Largest timestamp; must come last since later records pass the time check only at that same timestamp
    task automatic test_time_ceiling();
        send_record(rec_of(32'hFFFF_FFFF, 30'h3FFF_FFFF, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
        send_record(rec_of(32'hFFFF_FFFF, 30'h0, OWNER, ersc_pkg::KIND_OTHER, 64'h0));
    endtask

    initial
    begin : run
        rst_n               <= 1'b0;
        rec_ch.valid        <= 1'b0;
        rec_ch.time_sec     <= '0;
        rec_ch.time_nsec    <= '0;
        rec_ch.process_id   <= '0;
        rec_ch.event_kind   <= ersc_pkg::KIND_OTHER;
        rec_ch.signal_value <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_record_latch();
        test_directed_checks();
        test_hash_register_change();
        test_random_stream();
        test_output_backpressure();
        test_quiet_tail();
        test_time_ceiling();

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
